@@ rtl/buddy_block_allocator_unit_macros.svh @@
// Assertion helpers used by the allocator back end.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator package
// Sizes, codes, command types and helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEAF_LG     = 8;
    localparam int LEAF_COUNT  = 1 << LEAF_LG;
    localparam int MIN_LG      = 6;
    localparam int ARENA_SIZE  = LEAF_COUNT << MIN_LG;
    localparam int NODE_AW     = LEAF_LG + 1;
    localparam int VAL_W       = LEAF_LG + 1;
    localparam int LG_W        = 4;
    localparam int NODE_LAST   = (1 << NODE_AW) - 1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_SIZE = 2'd1,
        STAT_NO_SPACE = 2'd2,
        STAT_REFUSED  = 2'd3
    } t_status;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        t_op                 op;
        t_status             err;
        logic [LG_W-1:0]     need_lg;
        logic [LEAF_LG-1:0]  leaf;
    } t_cmd;

    // Status of the back end seen by the front end.
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CMP,
        S_U_RD,
        S_U_WR,
        S_F_RD,
        S_F_CHK,
        S_DONE
    } t_state;

    // Position of the highest set bit of a leaf count (zero for zero).
    function automatic logic [LG_W-1:0] msb_pos(input logic [LEAF_LG-1:0] v);
        logic [LG_W-1:0] p;
        p = '0;
        for (int i = 0; i < LEAF_LG; i++) begin
            if (v[i]) begin
                p = LG_W'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/bba_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request per beat.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] request_bytes;
    logic [15:0] free_offset;

    modport source (output valid, op, request_bytes, free_offset, input ready);
    modport sink   (input valid, op, request_bytes, free_offset, output ready);
endinterface

@@ rtl/bba_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one allocator result per beat.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [13:0] block_offset;
    logic [14:0] block_bytes;
    logic [14:0] max_free_bytes;

    modport source (output valid, status, block_offset, block_bytes, max_free_bytes,
                    input ready);
    modport sink   (input valid, status, block_offset, block_bytes, max_free_bytes,
                    output ready);
endinterface

@@ rtl/buddy_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over 256 blocks of 64 bytes, tree kept in memory.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  i_req    in   op, request_bytes, free_offset
//  o_rsp    out  status, block_offset, block_bytes, max_free_bytes
//
//  After reset the tree memory is initialised; no request beat is taken
//  in that time. An allocation walks down the tree level by level, then
//  rebuilds each parent on the way back up; a free climbs from the leaf
//  to the allocated node, frees it and rebuilds the parents above it, or
//  is refused at the root. Rejected requests and a whole-arena allocation
//  skip the walk.
//  A stalled result holds in the output register; two requests queue meanwhile.
module buddy_block_allocator_unit
    import bba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);

    t_cmd       w_front_cmd;
    logic       w_front_vld;
    logic       w_q_rdy;
    t_cmd       w_q_cmd;
    logic       w_q_vld;
    logic       w_pop;
    t_back_stat w_back_stat;

    bba_front u_front (
        .i_req       (i_req),
        .i_back_stat (w_back_stat),
        .i_cmd_rdy   (w_q_rdy),
        .o_cmd_vld   (w_front_vld),
        .o_cmd       (w_front_cmd)
    );

    bba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_cmd   (w_front_cmd),
        .o_rdy   (w_q_rdy),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_cmd   (w_q_cmd)
    );

    bba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (w_q_vld),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_back_stat (w_back_stat),
        .o_rsp       (o_rsp)
    );

endmodule

@@ rtl/bba_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator front end
// Accepts request beats, checks them and works out the leaf count needed.
// ----------------------------------------------------------------------------
module bba_front
    import bba_pkg::*;
(
    bba_req_if.sink    i_req,
    input  t_back_stat i_back_stat,
    input  logic       i_cmd_rdy,
    output logic       o_cmd_vld,
    output t_cmd       o_cmd
);

    logic [15:0]        w_req_m1;
    logic [LEAF_LG-1:0] w_m;
    logic               w_bad;
    logic               w_bad_free;

    // Nothing enters while the tree is being initialised.
    assign i_req.ready = i_cmd_rdy & ~i_back_stat.clearing;
    assign o_cmd_vld   = i_req.valid & ~i_back_stat.clearing;

    // Allocation size: reject zero and oversize, round up to a power of two leaves.
    assign w_req_m1 = i_req.request_bytes - 16'd1;
    assign w_m      = w_req_m1[MIN_LG +: LEAF_LG];
    assign w_bad    = (i_req.request_bytes == 16'd0) ||
                      (i_req.request_bytes > 16'(ARENA_SIZE));

    // Free offset must be block aligned and inside the arena.
    assign w_bad_free = (|i_req.free_offset[MIN_LG-1:0]) ||
                        (i_req.free_offset >= 16'(ARENA_SIZE));

    always_comb begin
        o_cmd.op   = t_op'(i_req.op);
        o_cmd.leaf = i_req.free_offset[MIN_LG +: LEAF_LG];
        if (i_req.request_bytes <= 16'(1 << MIN_LG)) begin
            o_cmd.need_lg = '0;
        end else begin
            o_cmd.need_lg = msb_pos(w_m) + LG_W'(1);
        end
        if (i_req.op == OP_FREE) begin
            o_cmd.err = w_bad_free ? STAT_REFUSED : STAT_OK;
        end else begin
            o_cmd.err = w_bad ? STAT_BAD_SIZE : STAT_OK;
        end
    end

endmodule

@@ rtl/bba_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator command queue
// Two-entry queue decoupling the front end from the tree walker.
// ----------------------------------------------------------------------------
module bba_queue
    import bba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_cmd i_cmd,
    output logic o_rdy,
    input  logic i_pop,
    output logic o_vld,
    output t_cmd o_cmd
);

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_rdy  = (r_cnt != 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_cmd  = r_ent[r_rp];
    assign w_push = i_vld & o_rdy;
    assign w_pop  = i_pop & o_vld;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

@@ rtl/bba_back.sv @@
`timescale 1ns / 1ps
`include "buddy_block_allocator_unit_macros.svh"
// ----------------------------------------------------------------------------
// Buddy allocator back end
// Walks the free-size tree in memory to allocate or free one block.
// ----------------------------------------------------------------------------
module bba_back
    import bba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_vld,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output t_back_stat o_back_stat,
    bba_rsp_if.source  o_rsp
);

    logic [VAL_W-1:0]   r_mem [1 << NODE_AW];
    logic [VAL_W-1:0]   r_rdata;
    logic [VAL_W-1:0]   r_root;

    t_state             r_state, n_state;
    logic [NODE_AW-1:0] r_idx, n_idx;
    logic [LG_W-1:0]    r_lg, n_lg;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [LG_W-1:0]    r_need_lg, n_need_lg;
    t_op                r_op, n_op;
    t_status            r_stat, n_stat;
    logic               r_ok, n_ok;
    logic [LG_W-1:0]    r_blk_lg, n_blk_lg;
    logic [LEAF_LG-1:0] r_off, n_off;
    logic [NODE_AW-1:0] r_clr_k, n_clr_k;
    logic [VAL_W-1:0]   r_clr_v, n_clr_v;

    logic               r_out_vld;
    t_status            r_out_stat;
    logic [13:0]        r_out_off;
    logic [14:0]        r_out_bytes;
    logic [14:0]        r_out_free;

    logic               w_we;
    logic [NODE_AW-1:0] w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic [NODE_AW-1:0] w_raddr;
    logic               w_load;

    logic [VAL_W-1:0]   w_need;
    logic [VAL_W-1:0]   w_cmd_need;
    logic [NODE_AW-1:0] w_child;
    logic [LG_W-1:0]    w_child_lg;
    logic [NODE_AW:0]   w_clr_inc;
    logic [VAL_W-1:0]   w_full;
    logic [VAL_W:0]     w_sum;
    logic [VAL_W-1:0]   w_pval;
    logic [NODE_AW-1:0] w_parent;
    logic [VAL_W-1:0]   w_bl;
    logic [LEAF_LG+NODE_AW-1:0] w_off_sh;

    assign o_back_stat.clearing = (r_state == S_CLEAR);
    assign w_load = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    // Shared arithmetic for the walk steps.
    assign w_need     = VAL_W'(1) << r_need_lg;
    assign w_cmd_need = VAL_W'(1) << i_cmd.need_lg;
    assign w_child    = {r_idx[NODE_AW-2:0], (r_rdata < w_need)};
    assign w_child_lg = r_lg - LG_W'(1);
    assign w_clr_inc  = {1'b0, r_clr_k} + (NODE_AW+1)'(1);
    assign w_full     = VAL_W'(1) << (r_lg + LG_W'(1));
    assign w_sum      = {1'b0, r_val} + {1'b0, r_rdata};
    assign w_parent   = {1'b0, r_idx[NODE_AW-1:1]};
    assign w_bl       = VAL_W'(1) << r_lg;
    assign w_off_sh   = (LEAF_LG+NODE_AW)'(w_child) << w_child_lg;

    always_comb begin
        if (w_sum == {1'b0, w_full}) begin
            w_pval = w_full;
        end else begin
            w_pval = (r_val > r_rdata) ? r_val : r_rdata;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_k == NODE_AW'(NODE_LAST)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_vld) begin
                    if (i_cmd.err != STAT_OK) begin
                        n_state = S_DONE;
                    end else if (i_cmd.op == OP_FREE) begin
                        n_state = S_F_RD;
                    end else if (r_root < w_cmd_need ||
                                 i_cmd.need_lg == LG_W'(LEAF_LG)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_A_RD;
                    end
                end
            end
            S_A_RD:  n_state = S_A_CMP;
            S_A_CMP: n_state = (w_child_lg == r_need_lg) ? S_U_RD : S_A_RD;
            S_U_RD:  n_state = S_U_WR;
            S_U_WR:  n_state = (w_parent == NODE_AW'(1)) ? S_DONE : S_U_RD;
            S_F_RD:  n_state = S_F_CHK;
            S_F_CHK: begin
                if (r_rdata == '0) begin
                    n_state = (r_idx == NODE_AW'(1)) ? S_DONE : S_U_RD;
                end else if (r_idx == NODE_AW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_DONE:  n_state = w_load ? S_IDLE : S_DONE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath and memory controls per state.
    always_comb begin
        n_idx     = r_idx;
        n_lg      = r_lg;
        n_val     = r_val;
        n_need_lg = r_need_lg;
        n_op      = r_op;
        n_stat    = r_stat;
        n_ok      = r_ok;
        n_blk_lg  = r_blk_lg;
        n_off     = r_off;
        n_clr_k   = r_clr_k;
        n_clr_v   = r_clr_v;
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = '0;
        w_raddr   = r_idx;
        o_pop     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_k;
                w_wdata = r_clr_v;
                n_clr_k = w_clr_inc[NODE_AW-1:0];
                if (({1'b0, r_clr_k} & w_clr_inc) == '0) begin
                    n_clr_v = r_clr_v >> 1;
                end
            end
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_pop     = 1'b1;
                    n_op      = i_cmd.op;
                    n_need_lg = i_cmd.need_lg;
                    n_stat    = i_cmd.err;
                    n_ok      = 1'b0;
                    n_off     = '0;
                    if (i_cmd.err == STAT_OK) begin
                        if (i_cmd.op == OP_FREE) begin
                            n_idx = {1'b1, i_cmd.leaf};
                            n_lg  = '0;
                        end else if (r_root < w_cmd_need) begin
                            n_stat = STAT_NO_SPACE;
                        end else if (i_cmd.need_lg == LG_W'(LEAF_LG)) begin
                            // Whole arena in one block.
                            w_we     = 1'b1;
                            w_waddr  = NODE_AW'(1);
                            n_ok     = 1'b1;
                            n_blk_lg = LG_W'(LEAF_LG);
                        end else begin
                            n_idx = NODE_AW'(1);
                            n_lg  = LG_W'(LEAF_LG);
                        end
                    end
                end
            end
            S_A_RD: begin
                w_raddr = {r_idx[NODE_AW-2:0], 1'b0};
            end
            S_A_CMP: begin
                // Go left if it can hold the request, else right.
                n_idx = w_child;
                n_lg  = w_child_lg;
                if (w_child_lg == r_need_lg) begin
                    w_we     = 1'b1;
                    w_waddr  = w_child;
                    n_val    = '0;
                    n_ok     = 1'b1;
                    n_blk_lg = w_child_lg;
                    n_off    = w_off_sh[LEAF_LG-1:0];
                end
            end
            S_U_RD: begin
                w_raddr = r_idx ^ NODE_AW'(1);
            end
            S_U_WR: begin
                // Rebuild the parent from this node and its buddy.
                w_we    = 1'b1;
                w_waddr = w_parent;
                w_wdata = w_pval;
                n_idx   = w_parent;
                n_val   = w_pval;
                n_lg    = r_lg + LG_W'(1);
            end
            S_F_RD: begin
                w_raddr = r_idx;
            end
            S_F_CHK: begin
                if (r_rdata == '0) begin
                    w_we     = 1'b1;
                    w_waddr  = r_idx;
                    w_wdata  = w_bl;
                    n_val    = w_bl;
                    n_ok     = 1'b1;
                    n_blk_lg = r_lg;
                end else if (r_idx == NODE_AW'(1)) begin
                    n_stat = STAT_REFUSED;
                end else begin
                    n_idx = w_parent;
                    n_lg  = r_lg + LG_W'(1);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Tree memory with registered read, and a copy of the root.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= VAL_W'(LEAF_COUNT);
        end else if (w_we && w_waddr == NODE_AW'(1)) begin
            r_root <= w_wdata;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_k   <= NODE_AW'(1);
            r_clr_v   <= VAL_W'(LEAF_COUNT);
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr_k <= n_clr_k;
            r_clr_v <= n_clr_v;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Walk registers and result beat.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_lg      <= n_lg;
        r_val     <= n_val;
        r_need_lg <= n_need_lg;
        r_op      <= n_op;
        r_stat    <= n_stat;
        r_ok      <= n_ok;
        r_blk_lg  <= n_blk_lg;
        r_off     <= n_off;
        if (w_load) begin
            r_out_stat  <= r_stat;
            r_out_off   <= (r_ok && r_op == OP_ALLOC) ? {r_off, MIN_LG'(0)} : '0;
            r_out_bytes <= r_ok ? (15'(1) << (r_blk_lg + LG_W'(MIN_LG))) : '0;
            r_out_free  <= {r_root, MIN_LG'(0)};
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.status         = r_out_stat;
    assign o_rsp.block_offset   = r_out_off;
    assign o_rsp.block_bytes    = r_out_bytes;
    assign o_rsp.max_free_bytes = r_out_free;

    `BBA_ASSERT_NOW(a_no_node_zero_write, w_we, w_waddr != '0, "write to unused node")
    `BBA_ASSERT_NOW(a_no_pop_clear, r_state == S_CLEAR, !o_pop, "pop during clear")
    `BBA_ASSERT_NEXT(a_done_loads, w_load, r_out_vld && r_state == S_IDLE, "result not loaded")

endmodule

@@ verif/buddy_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free requests with random gaps, stalls the result
// channel, and checks every result beat against an in-bench buddy tree.
// ----------------------------------------------------------------------------

// Scoreboard holding the predicted buddy tree and the pending results.
class buddy_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] offset;
        logic [14:0] bytes;
        logic [14:0] largest;
    } t_grant;

    int unsigned run_tree[511];
    t_grant      pending[$];
    int          errors;

    function void clear_tree();
        int unsigned sz;
        sz = 512;
        for (int i = 0; i < 511; i++) begin
            if (((i + 1) & i) == 0) begin
                sz = sz / 2;
            end
            run_tree[i] = sz;
        end
        pending.delete();
        errors = 0;
    endfunction

    function t_grant make(logic [1:0] st, int unsigned off, int unsigned by);
        t_grant g;
        g.status  = st;
        g.offset  = off[13:0];
        g.bytes   = by[14:0];
        g.largest = 15'(run_tree[0] * bba_pkg::LEAF_COUNT / bba_pkg::LEAF_COUNT * 64);
        return g;
    endfunction

    // Note one accepted request beat and queue its predicted result.
    function void note_request(logic op, logic [15:0] req, logic [15:0] off);
        int unsigned need, idx, sz, leaf, l, r, rel;
        need = 1;
        idx  = 0;
        sz   = 1;
        if (op == bba_pkg::OP_ALLOC) begin
            if (req == 0 || req > bba_pkg::ARENA_SIZE) begin
                pending.push_back(make(bba_pkg::STAT_BAD_SIZE, 0, 0));
                return;
            end
            while (need * 64 < req && need < 256) need = need * 2;
            if (run_tree[0] < need) begin
                pending.push_back(make(bba_pkg::STAT_NO_SPACE, 0, 0));
                return;
            end
            for (sz = 256; sz > need; sz = sz / 2) begin
                l = 2 * idx + 1;
                idx = (run_tree[l] >= need) ? l : l + 1;
            end
            run_tree[idx] = 0;
            leaf = (idx + 1) * sz - 256;
            while (idx != 0) begin
                idx = (idx - 1) / 2;
                l = run_tree[2 * idx + 1];
                r = run_tree[2 * idx + 2];
                run_tree[idx] = (l > r) ? l : r;
            end
            pending.push_back(make(bba_pkg::STAT_OK, leaf * 64, sz * 64));
            return;
        end
        if (off[5:0] != 0 || off >= bba_pkg::ARENA_SIZE) begin
            pending.push_back(make(bba_pkg::STAT_REFUSED, 0, 0));
            return;
        end
        idx = off / 64 + 255;
        while (run_tree[idx] != 0) begin
            if (idx == 0) begin
                pending.push_back(make(bba_pkg::STAT_REFUSED, 0, 0));
                return;
            end
            idx = (idx - 1) / 2;
            sz = sz * 2;
        end
        run_tree[idx] = sz;
        rel = sz;
        while (idx != 0) begin
            idx = (idx - 1) / 2;
            sz = sz * 2;
            l = run_tree[2 * idx + 1];
            r = run_tree[2 * idx + 2];
            run_tree[idx] = (l + r == sz) ? sz : ((l > r) ? l : r);
        end
        pending.push_back(make(bba_pkg::STAT_OK, 0, rel * 64));
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(logic [1:0] st, logic [13:0] off, logic [14:0] by,
                               logic [14:0] lg);
        t_grant g;
        if (pending.size() == 0) begin
            $error("unexpected result beat: status %0d", st);
            errors++;
            return;
        end
        g = pending.pop_front();
        if (st !== g.status) begin
            $error("status: expected %0d, got %0d", g.status, st);
            errors++;
        end
        if (off !== g.offset) begin
            $error("block_offset: expected %0d, got %0d", g.offset, off);
            errors++;
        end
        if (by !== g.bytes) begin
            $error("block_bytes: expected %0d, got %0d", g.bytes, by);
            errors++;
        end
        if (lg !== g.largest) begin
            $error("max_free_bytes: expected %0d, got %0d", g.largest, lg);
            errors++;
        end
    endfunction
endclass

module buddy_block_allocator_unit_tb;
    import bba_pkg::*;

    logic i_clk;
    logic i_rst_n;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_scoreboard board;
    logic [15:0] live_offsets[$];

    buddy_block_allocator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                board.note_request(req_ch.op, req_ch.request_bytes, req_ch.free_offset);
                if (req_ch.op == OP_ALLOC && board.pending[$].status == STAT_OK) begin
                    live_offsets.push_back(16'(board.pending[$].offset));
                end
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                board.check_result(rsp_ch.status, rsp_ch.block_offset,
                                   rsp_ch.block_bytes, rsp_ch.max_free_bytes);
            end
        end
    end

    // Receiver stall pattern: phases of no stall, light stall and heavy stall.
    initial begin
        int phase;
        rsp_ch.ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase = (phase + 1) % 400;
            if (phase < 100) begin
                rsp_ch.ready <= 1'b1;
            end else if (phase < 250) begin
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Present one request beat and hold it until taken.
    task automatic send_beat(logic op, logic [15:0] req, logic [15:0] off);
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.request_bytes <= req;
        req_ch.free_offset   <= off;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Bursts of back-to-back beats separated by idle gaps.
    int burst_left;
    task automatic send_item(logic op, logic [15:0] req, logic [15:0] off);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 40);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_beat(op, req, off);
    endtask

    task automatic random_item();
        logic [15:0] v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // Sizes within the arena, biased small.
            if ($urandom_range(0, 3) == 0) v = 16'($urandom_range(1, ARENA_SIZE));
            else v = 16'($urandom_range(1, 2048));
            send_item(OP_ALLOC, v, 16'($urandom));
        end else if (pick < 80 && live_offsets.size() > 0) begin
            int k;
            k = $urandom_range(0, live_offsets.size() - 1);
            v = live_offsets[k];
            live_offsets.delete(k);
            send_item(OP_FREE, 16'($urandom), v);
        end else if (pick < 90) begin
            send_item(OP_FREE, 16'($urandom), 16'($urandom_range(0, 255) * 64));
        end else begin
            send_item(logic'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
        end
    endtask

    // Stimulus and end of test.
    initial begin
        board = new();
        board.clear_tree();
        burst_left = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.free_offset = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: size extremes, rounding, full arena, refusals and merges.
        send_item(OP_ALLOC, 16'd0, 16'd0);
        send_item(OP_ALLOC, 16'hFFFF, 16'd0);
        send_item(OP_ALLOC, 16'(ARENA_SIZE + 1), 16'd0);
        send_item(OP_FREE, 16'd0, 16'd0);
        send_item(OP_ALLOC, 16'(ARENA_SIZE), 16'd0);
        send_item(OP_ALLOC, 16'd1, 16'd0);
        send_item(OP_FREE, 16'd0, 16'd0);
        send_item(OP_ALLOC, 16'd1, 16'd0);
        send_item(OP_ALLOC, 16'd65, 16'd0);
        send_item(OP_ALLOC, 16'd64, 16'd0);
        send_item(OP_FREE, 16'd0, 16'd33);
        send_item(OP_FREE, 16'd0, 16'hFFC0);
        send_item(OP_FREE, 16'd0, 16'(ARENA_SIZE));
        send_item(OP_FREE, 16'd0, 16'd192);
        send_item(OP_FREE, 16'd0, 16'd8192);
        send_item(OP_FREE, 16'd0, 16'd128);
        send_item(OP_FREE, 16'd0, 16'd0);
        send_item(OP_FREE, 16'd0, 16'd64);
        send_item(OP_FREE, 16'hFFFF, 16'd0);
        send_item(OP_ALLOC, 16'd8193, 16'hFFFF);

        repeat (700) random_item();
        req_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
